FILE: hdl/brle_pkg.sv
// shared types, constants and helpers for the byte rle decoder
package brle_pkg;

  localparam int MAX_PACKET_DEF = 127;
  // length, fill and address fields are sized for the largest legal packet
  localparam int LEN_W = 7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_BAD_HDR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_LITERAL,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_OUT
  } emit_state_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr_a;
    logic [LEN_W-1:0] addr_b;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] rem;
    logic             from_mem;
    logic [7:0]       run_byte;
    logic             fe;
    logic [1:0]       status;
    logic [15:0]      consumed;
    logic [15:0]      produced;
  } burst_t;

  typedef struct packed {
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [1:0]  byte_count;
    logic        last_of_input;
    logic        frame_done;
    logic [1:0]  status;
    logic [15:0] bytes_consumed;
    logic [15:0] bytes_produced;
  } result_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] n);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, n};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: hdl/byte_rle_decoder.sv
// top level of the packbits style byte rle decoder
//
//   channel   direction  payload
//   in_       input      data_byte, frame_end
//   out_      output     byte_first, byte_second, byte_count, last_of_input,
//                        frame_done, status, bytes_consumed, bytes_produced
//   cfg_      input      output_capacity
//
// an item that yields no output is taken without a stall; the next item follows at once.
// a run packet gives one output item per cycle while the receiver takes them; a literal packet
// reads the literal buffer ahead of each pair of bytes that it sends.
// input is held off while a burst is being sent; a waiting output item does not block it.
// reset is synchronous, active low; capacity returns to 65535 and the frame state clears.
module byte_rle_decoder #(
  parameter int MAX_PACKET = brle_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_output_capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_first,
  output logic [7:0]  out_byte_second,
  output logic [1:0]  out_byte_count,
  output logic        out_last_of_input,
  output logic        out_frame_done,
  output logic [1:0]  out_status,
  output logic [15:0] out_bytes_consumed,
  output logic [15:0] out_bytes_produced
);
  import brle_pkg::*;

  burst_t     burst;
  mem_wr_t    mem_wr;
  mem_rd_t    mem_rd;
  logic [7:0] rd_data_a;
  logic [7:0] rd_data_b;
  logic       emit_busy;
  result_t    result;

  brle_parse #(.MAX_PACKET(MAX_PACKET)) u_parse (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_frame_end        (in_frame_end),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .emit_busy           (emit_busy),
    .burst               (burst),
    .mem_wr              (mem_wr)
  );

  brle_lit_mem #(.MAX_PACKET(MAX_PACKET)) u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd        (mem_rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  brle_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .busy      (emit_busy),
    .mem_rd    (mem_rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_byte_first     = result.byte_first;
  assign out_byte_second    = result.byte_second;
  assign out_byte_count     = result.byte_count;
  assign out_last_of_input  = result.last_of_input;
  assign out_frame_done     = result.frame_done;
  assign out_status         = result.status;
  assign out_bytes_consumed = result.bytes_consumed;
  assign out_bytes_produced = result.bytes_produced;

endmodule

FILE: hdl/brle_lit_mem.sv
// literal byte buffer: one write port, two registered read ports
module brle_lit_mem #(
  parameter int MAX_PACKET = brle_pkg::MAX_PACKET_DEF
) (
  input  logic              clk,
  input  brle_pkg::mem_wr_t wr,
  input  brle_pkg::mem_rd_t rd,
  output logic [7:0]        rd_data_a,
  output logic [7:0]        rd_data_b
);
  import brle_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PACKET);

  logic [7:0] mem [0:MAX_PACKET-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  // second port may point one past the packet; that byte is masked downstream
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_a <= mem[rd.addr_a[ADDR_W-1:0]];
      rd_data_b <= mem[rd.addr_b[ADDR_W-1:0]];
    end
  end

endmodule

FILE: hdl/brle_parse.sv
// packet parser: header decode, literal fill, frame counters and status
module brle_parse #(
  parameter int MAX_PACKET = brle_pkg::MAX_PACKET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_output_capacity,
  input  logic               emit_busy,
  output brle_pkg::burst_t   burst,
  output brle_pkg::mem_wr_t  mem_wr
);
  import brle_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [15:0]      cons_r, cons_nxt;
  logic [15:0]      prod_r, prod_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [15:0]      cap_r, cap_nxt;

  logic             accept;
  logic [7:0]       mag;
  logic             fit;
  logic [LEN_W-1:0] fill_inc;
  logic             err;
  logic [1:0]       err_code;

  assign in_ready  = !emit_busy;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign mag       = in_data_byte[7] ? (~in_data_byte + 8'd1) : in_data_byte;
  assign fit       = ({1'b0, prod_r} + {{(17-LEN_W){1'b0}}, len_r}) <= {1'b0, cap_r};
  assign fill_inc  = fill_r + LEN_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    cons_nxt  = cons_r;
    prod_nxt  = prod_r;
    stat_nxt  = stat_r;
    cap_nxt   = cfg_valid ? cfg_output_capacity : cap_r;
    burst     = '0;
    mem_wr    = '0;
    err       = 1'b0;
    err_code  = ST_OK;

    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (in_data_byte == 8'd0) begin
            cons_nxt = sat_add(cons_r, 8'd1);
          end else if (mag > 8'(MAX_PACKET)) begin
            err      = 1'b1;
            err_code = ST_BAD_HDR;
          end else begin
            len_nxt   = mag[LEN_W-1:0];
            fill_nxt  = '0;
            phase_nxt = in_data_byte[7] ? PH_LITERAL : PH_RUN;
          end
        end
        PH_RUN: begin
          if (!fit) begin
            err      = 1'b1;
            err_code = ST_ERR;
          end else begin
            burst.rem      = len_r;
            burst.from_mem = 1'b0;
            burst.run_byte = in_data_byte;
            prod_nxt       = prod_r + {{(16-LEN_W){1'b0}}, len_r};
            cons_nxt       = sat_add(cons_r, 8'd2);
            phase_nxt      = PH_HEADER;
          end
        end
        PH_LITERAL: begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = fill_r;
          mem_wr.data = in_data_byte;
          fill_nxt    = fill_inc;
          if (fill_inc >= len_r) begin
            if (!fit) begin
              err      = 1'b1;
              err_code = ST_ERR;
            end else begin
              burst.rem      = len_r;
              burst.from_mem = 1'b1;
              prod_nxt       = prod_r + {{(16-LEN_W){1'b0}}, len_r};
              cons_nxt       = sat_add(cons_r, {1'b0, len_r} + 8'd1);
              phase_nxt      = PH_HEADER;
            end
          end
        end
        PH_DRAIN: begin
        end
        default: begin
        end
      endcase

      if (err) begin
        phase_nxt = PH_DRAIN;
        if (stat_r == ST_OK) stat_nxt = err_code;
      end

      // frame closes in the middle of a packet
      if (in_frame_end && (phase_nxt == PH_RUN || phase_nxt == PH_LITERAL)) begin
        phase_nxt = PH_DRAIN;
        if (stat_nxt == ST_OK) stat_nxt = ST_ERR;
      end

      burst.fe       = in_frame_end;
      burst.status   = stat_nxt;
      burst.consumed = cons_nxt;
      burst.produced = prod_nxt;
      burst.start    = (burst.rem != '0) || in_frame_end;

      if (in_frame_end) begin
        phase_nxt = PH_HEADER;
        len_nxt   = '0;
        fill_nxt  = '0;
        cons_nxt  = '0;
        prod_nxt  = '0;
        stat_nxt  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      len_r   <= '0;
      fill_r  <= '0;
      cons_r  <= '0;
      prod_r  <= '0;
      stat_r  <= ST_OK;
      cap_r   <= 16'hFFFF;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      cons_r  <= cons_nxt;
      prod_r  <= prod_nxt;
      stat_r  <= stat_nxt;
      cap_r   <= cap_nxt;
    end
  end

endmodule

FILE: hdl/brle_emit.sv
// burst sequencer: reads the literal buffer or repeats a run byte, up to two bytes per item
module brle_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  brle_pkg::burst_t   burst,
  output logic               busy,
  output brle_pkg::mem_rd_t  mem_rd,
  input  logic [7:0]         rd_data_a,
  input  logic [7:0]         rd_data_b,
  output logic               out_valid,
  input  logic               out_ready,
  output brle_pkg::result_t  result
);
  import brle_pkg::*;

  emit_state_t      state_r, state_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic             from_mem_r, from_mem_nxt;
  logic [7:0]       run_byte_r, run_byte_nxt;
  logic             fe_r, fe_nxt;
  logic [1:0]       sum_stat_r, sum_stat_nxt;
  logic [15:0]      sum_cons_r, sum_cons_nxt;
  logic [15:0]      sum_prod_r, sum_prod_nxt;

  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic             out_free;
  logic [1:0]       cnt;
  logic             last;
  logic [7:0]       b0, b1;

  assign busy      = (state_r != EM_IDLE);
  assign out_valid = out_valid_r;
  assign result    = res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign cnt       = (rem_r >= LEN_W'(2)) ? 2'd2 : rem_r[1:0];
  assign last      = (rem_r <= LEN_W'(2));
  assign b0        = from_mem_r ? rd_data_a : run_byte_r;
  assign b1        = from_mem_r ? rd_data_b : run_byte_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    from_mem_nxt  = from_mem_r;
    run_byte_nxt  = run_byte_r;
    fe_nxt        = fe_r;
    sum_stat_nxt  = sum_stat_r;
    sum_cons_nxt  = sum_cons_r;
    sum_prod_nxt  = sum_prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    mem_rd.en     = 1'b0;
    mem_rd.addr_a = ptr_r;
    mem_rd.addr_b = ptr_r + LEN_W'(1);

    unique case (state_r)
      EM_IDLE: begin
        if (burst.start) begin
          rem_nxt      = burst.rem;
          ptr_nxt      = '0;
          from_mem_nxt = burst.from_mem;
          run_byte_nxt = burst.run_byte;
          fe_nxt       = burst.fe;
          sum_stat_nxt = burst.status;
          sum_cons_nxt = burst.consumed;
          sum_prod_nxt = burst.produced;
          state_nxt    = burst.from_mem ? EM_READ : EM_OUT;
        end
      end
      EM_READ: begin
        mem_rd.en = 1'b1;
        state_nxt = EM_OUT;
      end
      EM_OUT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          res_nxt.byte_first     = (cnt != 2'd0) ? b0 : 8'd0;
          res_nxt.byte_second    = (cnt == 2'd2) ? b1 : 8'd0;
          res_nxt.byte_count     = cnt;
          res_nxt.last_of_input  = last;
          res_nxt.frame_done     = last && fe_r;
          res_nxt.status         = (last && fe_r) ? sum_stat_r : 2'd0;
          res_nxt.bytes_consumed = (last && fe_r) ? sum_cons_r : 16'd0;
          res_nxt.bytes_produced = (last && fe_r) ? sum_prod_r : 16'd0;
          rem_nxt                = rem_r - {{(LEN_W-2){1'b0}}, cnt};
          ptr_nxt                = ptr_r + LEN_W'(2);
          if (last) begin
            state_nxt = EM_IDLE;
          end else begin
            state_nxt = from_mem_r ? EM_READ : EM_OUT;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      ptr_r       <= '0;
      fe_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      ptr_r       <= ptr_nxt;
      fe_r        <= fe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_mem_r <= from_mem_nxt;
    run_byte_r <= run_byte_nxt;
    sum_stat_r <= sum_stat_nxt;
    sum_cons_r <= sum_cons_nxt;
    sum_prod_r <= sum_prod_nxt;
    res_r      <= res_nxt;
  end

endmodule

FILE: test/tb_byte_rle_decoder.sv
// testbench for the byte rle decoder: own decoder model in a scoreboard, directed and random frames
module tb_byte_rle_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import brle_pkg::*;

  localparam int STUCK_LIMIT = 3000;

  // expected results come from a private copy of the frame decoder state
  class rle_scoreboard;
    logic [15:0] capacity;
    phase_t      ph;
    logic [6:0]  pkt_len;
    int          lit_fill;
    logic [7:0]  lit_buf [MAX_PACKET_DEF];
    logic [15:0] consumed;
    logic [15:0] produced;
    logic [1:0]  fstat;
    result_t     pending_q[$];
    int          errors;

    function new();
      capacity = 16'hFFFF;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph = PH_HEADER;
      pkt_len = '0;
      lit_fill = 0;
      consumed = '0;
      produced = '0;
      fstat = ST_OK;
    endfunction

    function void add_consumed(int n);
      int s;
      s = int'(consumed) + n;
      consumed = (s > 65535) ? 16'hFFFF : 16'(s);
    endfunction

    // the first error of a frame sticks, the rest of the frame is dropped
    function void flag_error(logic [1:0] code);
      if (fstat == ST_OK) fstat = code;
      ph = PH_DRAIN;
    endfunction

    function bit room_for(int n);
      return int'(produced) + n <= int'(capacity);
    endfunction

    function void note_input(logic [7:0] b, logic fe);
      logic [7:0] dec [MAX_PACKET_DEF + 1];
      int         nb;
      int         mag;
      int         i;
      result_t    r;
      result_t    burst[$];
      nb = 0;
      case (ph)
        PH_HEADER: begin
          if (b == 8'h00) begin
            add_consumed(1);
          end else begin
            mag = (b < 8'h80) ? int'(b) : 256 - int'(b);
            if (mag > MAX_PACKET_DEF) begin
              flag_error(ST_BAD_HDR);
            end else begin
              pkt_len = mag[6:0];
              lit_fill = 0;
              ph = (b < 8'h80) ? PH_RUN : PH_LITERAL;
            end
          end
        end
        PH_RUN: begin
          if (!room_for(int'(pkt_len))) begin
            flag_error(ST_ERR);
          end else begin
            for (i = 0; i < int'(pkt_len); i++) dec[i] = b;
            nb = pkt_len;
            produced = produced + 16'(nb);
            add_consumed(2);
            ph = PH_HEADER;
          end
        end
        PH_LITERAL: begin
          if (lit_fill < MAX_PACKET_DEF) lit_buf[lit_fill] = b;
          lit_fill++;
          if (lit_fill >= int'(pkt_len)) begin
            if (!room_for(int'(pkt_len))) begin
              flag_error(ST_ERR);
            end else begin
              for (i = 0; i < int'(pkt_len); i++) dec[i] = lit_buf[i];
              nb = pkt_len;
              produced = produced + 16'(nb);
              add_consumed(1 + int'(pkt_len));
              ph = PH_HEADER;
            end
          end
        end
        default: ;
      endcase

      // frame end in the middle of a packet
      if (fe && (ph == PH_RUN || ph == PH_LITERAL)) flag_error(ST_ERR);

      for (i = 0; i < nb; i += 2) begin
        r = '0;
        r.byte_first = dec[i];
        if (nb - i >= 2) begin
          r.byte_second = dec[i + 1];
          r.byte_count = 2'd2;
        end else begin
          r.byte_count = 2'd1;
        end
        burst.push_back(r);
      end
      if (fe && burst.size() == 0) begin
        r = '0;
        burst.push_back(r);
      end
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.last_of_input = 1'b1;
        if (fe) begin
          r.frame_done = 1'b1;
          r.status = fstat;
          r.bytes_consumed = consumed;
          r.bytes_produced = produced;
        end
        burst.push_back(r);
      end
      foreach (burst[k]) pending_q.push_back(burst[k]);
      if (fe) clear_frame();
    endfunction

    function void cmp(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: byte_first %0d byte_count %0d",
               got.byte_first, got.byte_count);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      cmp("byte_first", want.byte_first, got.byte_first);
      cmp("byte_second", want.byte_second, got.byte_second);
      cmp("byte_count", want.byte_count, got.byte_count);
      cmp("last_of_input", want.last_of_input, got.last_of_input);
      cmp("frame_done", want.frame_done, got.frame_done);
      cmp("status", want.status, got.status);
      cmp("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
      cmp("bytes_produced", want.bytes_produced, got.bytes_produced);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_output_capacity;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte_first;
  logic [7:0]  out_byte_second;
  logic [1:0]  out_byte_count;
  logic        out_last_of_input;
  logic        out_frame_done;
  logic [1:0]  out_status;
  logic [15:0] out_bytes_consumed;
  logic [15:0] out_bytes_produced;

  result_t       seen_item;
  rle_scoreboard sb = new();
  bit            calm;
  int            items_sent;
  int            stuck;
  int            hold;

  byte_rle_decoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_frame_end        (in_frame_end),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte_first      (out_byte_first),
    .out_byte_second     (out_byte_second),
    .out_byte_count      (out_byte_count),
    .out_last_of_input   (out_last_of_input),
    .out_frame_done      (out_frame_done),
    .out_status          (out_status),
    .out_bytes_consumed  (out_bytes_consumed),
    .out_bytes_produced  (out_bytes_produced)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  assign seen_item = {out_byte_first, out_byte_second, out_byte_count, out_last_of_input,
                      out_frame_done, out_status, out_bytes_consumed, out_bytes_produced};

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready) sb.check_result(seen_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck = 0;
    else
      stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb_byte_rle_decoder: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 8);
    return $urandom_range(9, 127);
  endfunction

  // receiver back-pressure, off in calm stretches
  initial begin
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic fe);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_frame_end = fe;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, fe);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    wait_drained();
    // items with no result may still be in flight
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_output_capacity = v;
    do @(posedge clk); while (!cfg_ready);
    sb.capacity = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_frame();
    logic [7:0] fq[$];
    int         npk;
    int         kind;
    int         len;
    bit         stop;
    npk = $urandom_range(1, 5);
    stop = 1'b0;
    for (int k = 0; k < npk && !stop; k++) begin
      kind = $urandom_range(0, 99);
      len = pick_len();
      if (kind < 40) begin
        fq.push_back(8'(len));
        fq.push_back(8'($urandom));
      end else if (kind < 75) begin
        fq.push_back(8'(256 - len));
        repeat (len) fq.push_back(8'($urandom));
      end else if (kind < 83) begin
        fq.push_back(8'h00);
      end else if (kind < 88) begin
        fq.push_back(8'h80);
        repeat ($urandom_range(0, 2)) fq.push_back(8'($urandom));
        stop = 1'b1;
      end else if (kind < 94) begin
        // packet cut short by the frame end
        if ($urandom_range(0, 1) == 1) begin
          fq.push_back(8'(len));
        end else begin
          fq.push_back(8'(256 - len));
          repeat ($urandom_range(0, len - 1)) fq.push_back(8'($urandom));
        end
        stop = 1'b1;
      end else begin
        fq.push_back(8'($urandom));
      end
    end
    foreach (fq[i]) send_byte(fq[i], i == fq.size() - 1);
  endtask

  initial begin
    int          start;
    logic [15:0] cap_v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_output_capacity = '0;
    calm = 1'b0;
    items_sent = 0;
    stuck = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // run, literal with extreme bytes, zero header, longest run
    send_byte(8'h03, 1'b0); send_byte(8'hAA, 1'b0);
    send_byte(8'hFD, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h5A, 1'b1);
    wait_drained();
    // invalid header, rest of frame ignored
    send_byte(8'h80, 1'b0); send_byte(8'h12, 1'b0); send_byte(8'h01, 1'b1);
    // truncated run and truncated literal
    send_byte(8'h02, 1'b1);
    send_byte(8'hFE, 1'b0); send_byte(8'h11, 1'b1);
    // empty frame, then a single byte run
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b1);
    // out of space on the second packet
    write_capacity(16'd4);
    send_byte(8'h04, 1'b0); send_byte(8'h77, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h42, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cap_v = 16'hFFFF;
        1: cap_v = 16'h0000;
        2: cap_v = 16'd1;
        3: cap_v = 16'($urandom_range(2, 40));
        4: cap_v = 16'($urandom_range(41, 65534));
        default: cap_v = 16'hFFFF;
      endcase
      calm = 1'b0;
      write_capacity(cap_v);
      calm = (p == 4) || ($urandom_range(0, 3) == 0);
      start = items_sent;
      if (p == 0) begin
        // longest literal packet
        send_byte(8'h81, 1'b0);
        for (int j = 0; j < MAX_PACKET_DEF; j++)
          send_byte(8'($urandom), j == MAX_PACKET_DEF - 1);
      end
      while (items_sent - start < 4) begin
        random_frame();
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_byte_rle_decoder: clean");
    else
      $display("tb_byte_rle_decoder: errors");
    $finish;
  end

endmodule
